// ===== rtl/script_token_lexer_macros.svh =====
// assertion macros shared by the lexer checker
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define STL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stl_pkg.sv =====
// shared types, constants and character helpers for the script lexer
package stl_pkg;

    typedef enum logic [3:0] {
        M_TOP     = 4'd0,
        M_KW      = 4'd1,
        M_IDENT   = 4'd2,
        M_INT     = 4'd3,
        M_STR     = 4'd4,
        M_TYPE    = 4'd5,
        M_COMMENT = 4'd6,
        M_BRACE   = 4'd7,
        M_BIDENT  = 4'd8,
        M_BINT    = 4'd9,
        M_BSTR    = 4'd10
    } t_mode;

    typedef enum logic [3:0] {
        TT_VAR     = 4'd0,
        TT_TYPE    = 4'd1,
        TT_ASSIGN  = 4'd2,
        TT_STRING  = 4'd3,
        TT_INT     = 4'd4,
        TT_COMMENT = 4'd5,
        TT_OUTPUT  = 4'd6,
        TT_OPEN    = 4'd7,
        TT_CLOSE   = 4'd8,
        TT_END     = 4'd9
    } t_tok;

    // one result item
    typedef struct packed {
        t_tok       tok;
        logic       has;
        logic [7:0] chr;
        logic       first;
        logic       last;
    } t_res;

    // work for one input item: optional keyword letters, then up to two results
    typedef struct packed {
        logic [2:0] kw_cnt;
        logic       kw_out;
        logic [1:0] ex_cnt;
        t_res       ex1;
        t_res       ex0;
    } t_cmd;

    localparam logic [2:0]  KW_LEN    = 3'd6;
    localparam logic [15:0] LIMIT_RST = 16'd100;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BIG_O  = 8'h4F;

    // letters of the keyword Output
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h4F;
            3'd1: c = 8'h75;
            3'd2: c = 8'h74;
            3'd3: c = 8'h70;
            3'd4: c = 8'h75;
            3'd5: c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
    endfunction

    function automatic t_res mk_res(input t_tok tok, input logic has, input logic [7:0] chr,
                                    input logic first, input logic last);
        t_res r;
        r.tok   = tok;
        r.has   = has;
        r.chr   = chr;
        r.first = first;
        r.last  = last;
        return r;
    endfunction

endpackage

// ===== rtl/script_token_lexer.sv =====
// top level of the streaming script lexer
//
// usage
// - input side is a queue: drive a source byte (or end_of_source) with push;
//   the item is taken at a rising edge with push high and full low
// - result side is a queue: the oldest result sits on the o_ ports while
//   empty is low and leaves at an edge with pop high
// - token_limit is written through i_cfg_we / i_cfg_wdata, no read-back
// timing
// - the edge that takes an item classifies it and queues its command; the back
//   end later loads each result from the command queue into the output register
// - one item per cycle is taken while each causes at most one result and the
//   output is popped; the back end gives one result per cycle unless pop is low,
//   an item with k results holds it for all k; the QUEUE_DEPTH queue absorbs bursts
// - items causing no result use no back-end time
// reset
// - clears lexer mode, keyword progress, token count and both queues;
//   token_limit returns to 100
// stall
// - with pop low the output register holds; the back end stops, the command
//   queue fills, and full rises so that push is refused
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source items
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_value,
    input  logic        i_end_of_source,
    // results
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_lex_kind,
    output logic        o_has_byte,
    output logic [7:0]  o_lexeme_byte,
    output logic        o_token_first,
    output logic        o_token_last,
    output logic        o_run_last,
    // token_limit register
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic acc;
    t_cmd cmd_in, cmd_out;
    logic cmd_push, cmd_pop, cmd_vld, q_full;
    t_res res;
    logic res_vld;

    // item taken whenever the command queue has room
    assign acc  = push && !q_full;
    assign full = q_full;

    // front end: classify the byte, advance lexer state
    stl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_char      (i_char_value),
        .i_eos       (i_end_of_source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd       (cmd_in),
        .o_cmd_vld   (cmd_push)
    );

    // decoupling queue of commands
    stl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_data   (cmd_in),
        .o_full   (q_full),
        .i_pop    (cmd_pop),
        .o_data   (cmd_out),
        .o_nempty (cmd_vld)
    );

    // back end: expand commands into result items
    stl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_out),
        .i_cmd_vld  (cmd_vld),
        .o_cmd_pop  (cmd_pop),
        .o_res      (res),
        .o_run_last (o_run_last),
        .o_vld      (res_vld),
        .i_pop      (pop)
    );

    assign empty         = !res_vld;
    assign o_lex_kind    = res.tok;
    assign o_has_byte    = res.has;
    assign o_lexeme_byte = res.chr;
    assign o_token_first = res.first;
    assign o_token_last  = res.last;

endmodule

// ===== rtl/stl_front.sv =====
// front end: lexer state, token count and per-item classification into a command
module stl_front
    import stl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  logic [7:0]  i_char,
    input  logic        i_eos,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_cmd        o_cmd,
    output logic        o_cmd_vld
);

    typedef struct packed {
        logic  vld;
        t_res  res;
        t_mode mode;
        logic  kw;
        logic  cnt;
        logic  ts;
    } t_start;

    logic [15:0] r_limit;
    t_mode       r_mode, n_mode;
    logic [2:0]  r_kw, n_kw;
    logic [15:0] r_te, n_te;
    logic        r_ts, n_ts;

    logic [15:0] te_inc1;
    logic        lim0, lim1;
    logic [1:0]  inc;
    logic [16:0] te_sum;
    t_start      st_top0, st_top1, st_br;
    t_cmd        cmd;

    function automatic t_start top_start(input logic [7:0] c, input logic lim);
        t_start s;
        s      = '0;
        s.mode = M_TOP;
        if (!(lim || is_space(c))) begin
            priority if (c == CH_BIG_O) begin
                s.mode = M_KW;
                s.kw   = 1'b1;
            end else if (c == CH_LBRACE) begin
                s.vld  = 1'b1;
                s.res  = mk_res(TT_OPEN, 1'b1, c, 1'b1, 1'b1);
                s.cnt  = 1'b1;
                s.mode = M_BRACE;
            end else if (c == CH_COLON) begin
                s.vld  = 1'b1;
                s.res  = mk_res(TT_ASSIGN, 1'b1, c, 1'b1, 1'b1);
                s.cnt  = 1'b1;
            end else if (c == CH_LPAREN) begin
                s.mode = M_TYPE;
            end else if (is_digit(c)) begin
                s.vld  = 1'b1;
                s.res  = mk_res(TT_INT, 1'b1, c, 1'b1, 1'b0);
                s.ts   = 1'b1;
                s.mode = M_INT;
            end else if (is_alpha(c) || c == CH_USCORE) begin
                s.vld  = 1'b1;
                s.res  = mk_res(TT_VAR, 1'b1, c, 1'b1, 1'b0);
                s.ts   = 1'b1;
                s.mode = M_IDENT;
            end else if (c == CH_QUOTE) begin
                s.mode = M_STR;
            end else if (c == CH_AT) begin
                s.vld  = 1'b1;
                s.res  = mk_res(TT_COMMENT, 1'b1, c, 1'b1, 1'b0);
                s.ts   = 1'b1;
                s.mode = M_COMMENT;
            end else begin
                s.mode = M_TOP;
            end
        end
        return s;
    endfunction

    function automatic t_start brace_start(input logic [7:0] c);
        t_start s;
        s      = '0;
        s.mode = M_BRACE;
        priority if (c == CH_RBRACE) begin
            s.vld  = 1'b1;
            s.res  = mk_res(TT_CLOSE, 1'b1, c, 1'b1, 1'b1);
            s.cnt  = 1'b1;
            s.mode = M_TOP;
        end else if (c == CH_QUOTE) begin
            s.mode = M_BSTR;
        end else if (is_digit(c)) begin
            s.vld  = 1'b1;
            s.res  = mk_res(TT_INT, 1'b1, c, 1'b1, 1'b0);
            s.ts   = 1'b1;
            s.mode = M_BINT;
        end else if (is_alpha(c) || c == CH_USCORE) begin
            s.vld  = 1'b1;
            s.res  = mk_res(TT_VAR, 1'b1, c, 1'b1, 1'b0);
            s.ts   = 1'b1;
            s.mode = M_BIDENT;
        end else begin
            s.mode = M_BRACE;
        end
        return s;
    endfunction

    function automatic t_cmd add_res(input t_cmd c, input t_res r);
        t_cmd o;
        o = c;
        if (c.ex_cnt == 2'd0) begin
            o.ex0 = r;
        end else begin
            o.ex1 = r;
        end
        o.ex_cnt = c.ex_cnt + 2'd1;
        return o;
    endfunction

    // limit check before and after a token closed earlier in the same item
    assign te_inc1 = (r_te == 16'hFFFF) ? r_te : r_te + 16'd1;
    assign lim0    = r_te >= r_limit;
    assign lim1    = te_inc1 >= r_limit;

    assign st_top0 = top_start(i_char, lim0);
    assign st_top1 = top_start(i_char, lim1);
    assign st_br   = brace_start(i_char);

    always_comb begin
        n_mode = r_mode;
        n_kw   = r_kw;
        n_ts   = r_ts;
        inc    = 2'd0;
        cmd    = '0;
        if (i_eos) begin
            unique case (r_mode)
                M_KW: begin
                    cmd.kw_cnt = r_kw;
                    cmd = add_res(cmd, mk_res(TT_VAR, 1'b0, 8'h00, 1'b0, 1'b1));
                end
                M_IDENT, M_BIDENT: begin
                    cmd = add_res(cmd, mk_res(TT_VAR, 1'b0, 8'h00, !r_ts, 1'b1));
                end
                M_INT, M_BINT: begin
                    cmd = add_res(cmd, mk_res(TT_INT, 1'b0, 8'h00, !r_ts, 1'b1));
                end
                M_STR, M_BSTR: begin
                    cmd = add_res(cmd, mk_res(TT_STRING, 1'b0, 8'h00, !r_ts, 1'b1));
                end
                M_TYPE: begin
                    cmd = add_res(cmd, mk_res(TT_TYPE, 1'b0, 8'h00, !r_ts, 1'b1));
                end
                M_COMMENT: begin
                    cmd = add_res(cmd, mk_res(TT_COMMENT, 1'b0, 8'h00, !r_ts, 1'b1));
                end
                default: begin
                end
            endcase
            cmd    = add_res(cmd, mk_res(TT_END, 1'b0, 8'h00, 1'b1, 1'b1));
            n_mode = M_TOP;
            n_kw   = 3'd0;
            n_ts   = 1'b0;
        end else begin
            unique case (r_mode)
                M_KW: begin
                    priority if (r_kw < KW_LEN && i_char == kw_char(r_kw)) begin
                        n_kw = r_kw + 3'd1;
                    end else if (r_kw >= KW_LEN &&
                                 (is_space(i_char) || i_char == CH_LBRACE)) begin
                        // complete keyword, then the terminator starts afresh
                        cmd.kw_cnt = KW_LEN;
                        cmd.kw_out = 1'b1;
                        if (st_top1.vld) begin
                            cmd = add_res(cmd, st_top1.res);
                        end
                        n_mode = st_top1.mode;
                        n_kw   = {2'b00, st_top1.kw};
                        n_ts   = st_top1.ts;
                        inc    = 2'd1 + {1'b0, st_top1.cnt};
                    end else if (is_ident(i_char)) begin
                        cmd.kw_cnt = r_kw;
                        cmd    = add_res(cmd, mk_res(TT_VAR, 1'b1, i_char, 1'b0, 1'b0));
                        n_mode = M_IDENT;
                        n_kw   = 3'd0;
                        n_ts   = 1'b1;
                    end else begin
                        cmd.kw_cnt = r_kw;
                        cmd = add_res(cmd, mk_res(TT_VAR, 1'b0, 8'h00, 1'b0, 1'b1));
                        if (st_top1.vld) begin
                            cmd = add_res(cmd, st_top1.res);
                        end
                        n_mode = st_top1.mode;
                        n_kw   = {2'b00, st_top1.kw};
                        n_ts   = st_top1.ts;
                        inc    = 2'd1 + {1'b0, st_top1.cnt};
                    end
                end
                M_IDENT, M_BIDENT, M_INT, M_BINT: begin
                    if ((r_mode == M_IDENT || r_mode == M_BIDENT) ? is_ident(i_char)
                                                                 : is_digit(i_char)) begin
                        cmd = add_res(cmd, mk_res(
                            (r_mode == M_IDENT || r_mode == M_BIDENT) ? TT_VAR : TT_INT,
                            1'b1, i_char, !r_ts, 1'b0));
                        n_ts = 1'b1;
                    end else begin
                        cmd = add_res(cmd, mk_res(
                            (r_mode == M_IDENT || r_mode == M_BIDENT) ? TT_VAR : TT_INT,
                            1'b0, 8'h00, !r_ts, 1'b1));
                        if (r_mode == M_BIDENT || r_mode == M_BINT) begin
                            if (st_br.vld) begin
                                cmd = add_res(cmd, st_br.res);
                            end
                            n_mode = st_br.mode;
                            n_kw   = 3'd0;
                            n_ts   = st_br.ts;
                            inc    = 2'd1 + {1'b0, st_br.cnt};
                        end else begin
                            if (st_top1.vld) begin
                                cmd = add_res(cmd, st_top1.res);
                            end
                            n_mode = st_top1.mode;
                            n_kw   = {2'b00, st_top1.kw};
                            n_ts   = st_top1.ts;
                            inc    = 2'd1 + {1'b0, st_top1.cnt};
                        end
                    end
                end
                M_STR, M_BSTR: begin
                    if (i_char == CH_QUOTE) begin
                        cmd = add_res(cmd, mk_res(TT_STRING, 1'b0, 8'h00, !r_ts, 1'b1));
                        n_mode = (r_mode == M_BSTR) ? M_BRACE : M_TOP;
                        n_ts   = 1'b0;
                        inc    = 2'd1;
                    end else if (!i_char[7]) begin
                        cmd  = add_res(cmd, mk_res(TT_STRING, 1'b1, i_char, !r_ts, 1'b0));
                        n_ts = 1'b1;
                    end
                end
                M_TYPE: begin
                    if (i_char == CH_RPAREN) begin
                        cmd = add_res(cmd, mk_res(TT_TYPE, 1'b0, 8'h00, !r_ts, 1'b1));
                        n_mode = M_TOP;
                        n_ts   = 1'b0;
                        inc    = 2'd1;
                    end else if (!i_char[7]) begin
                        cmd  = add_res(cmd, mk_res(TT_TYPE, 1'b1, i_char, !r_ts, 1'b0));
                        n_ts = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_char == CH_NL) begin
                        cmd = add_res(cmd, mk_res(TT_COMMENT, 1'b0, 8'h00, !r_ts, 1'b1));
                        n_mode = M_TOP;
                        n_ts   = 1'b0;
                        inc    = 2'd1;
                    end else if (!i_char[7]) begin
                        cmd  = add_res(cmd, mk_res(TT_COMMENT, 1'b1, i_char, !r_ts, 1'b0));
                        n_ts = 1'b1;
                    end
                end
                M_BRACE: begin
                    if (st_br.vld) begin
                        cmd = add_res(cmd, st_br.res);
                    end
                    n_mode = st_br.mode;
                    n_ts   = st_br.ts;
                    inc    = {1'b0, st_br.cnt};
                end
                default: begin
                    if (st_top0.vld) begin
                        cmd = add_res(cmd, st_top0.res);
                    end
                    n_mode = st_top0.mode;
                    n_kw   = {2'b00, st_top0.kw};
                    n_ts   = st_top0.ts;
                    inc    = {1'b0, st_top0.cnt};
                end
            endcase
        end
    end

    // saturating token count, cleared by end of source
    assign te_sum = {1'b0, r_te} + {15'd0, inc};
    assign n_te   = i_eos ? 16'd0 : (te_sum[16] ? 16'hFFFF : te_sum[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
            r_mode  <= M_TOP;
            r_kw    <= 3'd0;
            r_te    <= 16'd0;
            r_ts    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_acc) begin
                r_mode <= n_mode;
                r_kw   <= n_kw;
                r_te   <= n_te;
                r_ts   <= n_ts;
            end
        end
    end

    assign o_cmd     = cmd;
    assign o_cmd_vld = i_acc && (cmd.kw_cnt != 3'd0 || cmd.ex_cnt != 2'd0);

endmodule

// ===== rtl/stl_fifo.sv =====
// small command queue between the front and back ends
module stl_fifo
    import stl_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_nempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign do_push  = i_push && (r_cnt != CNT_FULL);
    assign do_pop   = i_pop && (r_cnt != '0);
    assign o_full   = r_cnt == CNT_FULL;
    assign o_nempty = r_cnt != '0;
    assign o_data   = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/stl_back.sv =====
// back end: expands a command into output-register results, one per cycle unless stalled
module stl_back
    import stl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_vld,
    output logic o_cmd_pop,
    output t_res o_res,
    output logic o_run_last,
    output logic o_vld,
    input  logic i_pop
);

    logic [2:0] r_idx;
    logic       r_vld;
    t_res       r_res;
    logic       r_run_last;

    logic [3:0] total;
    logic       last_res;
    logic [2:0] ex_idx;
    t_res       cur;
    logic       adv;

    assign total    = {1'b0, i_cmd.kw_cnt} + {2'b00, i_cmd.ex_cnt};
    assign last_res = {1'b0, r_idx} == (total - 4'd1);
    assign ex_idx   = r_idx - i_cmd.kw_cnt;

    // keyword letters first, then the explicit results
    always_comb begin
        if (r_idx < i_cmd.kw_cnt) begin
            cur = mk_res(i_cmd.kw_out ? TT_OUTPUT : TT_VAR, 1'b1, kw_char(r_idx),
                         r_idx == 3'd0, i_cmd.kw_out && (r_idx == KW_LEN - 3'd1));
        end else begin
            cur = ex_idx[0] ? i_cmd.ex1 : i_cmd.ex0;
        end
    end

    assign adv       = i_cmd_vld && (!r_vld || i_pop);
    assign o_cmd_pop = adv && last_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= 1'b1;
            r_idx <= last_res ? 3'd0 : r_idx + 3'd1;
        end else if (i_pop) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res      <= cur;
            r_run_last <= last_res;
        end
    end

    assign o_res      = r_res;
    assign o_run_last = r_run_last;
    assign o_vld      = r_vld;

endmodule

// ===== rtl/stl_checker.sv =====
// port-level checks for the script lexer, bound to the top level
`include "script_token_lexer_macros.svh"

module stl_checker
    import stl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [3:0] o_lex_kind,
    input logic       o_has_byte,
    input logic [7:0] o_lexeme_byte,
    input logic       o_token_first,
    input logic       o_token_last,
    input logic       o_run_last
);

    // nothing to pop straight after reset
    `STL_ASSERT_NOW(a_empty_after_reset, !$past(i_rst_n), empty, "result shown after reset")

    // a stalled result holds
    `STL_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(o_lex_kind) && $stable(o_lexeme_byte) && $stable(o_run_last), "stalled result changed")

    // the rest of an item's results follow without a gap
    `STL_ASSERT_NEXT(a_run_gapless, pop && !empty && !o_run_last, !empty, "gap inside an item's results")

    // markers always close a token; end is a lone closing marker
    `STL_ASSERT_NOW(a_marker_closes, !empty && !o_has_byte, o_token_last, "marker without token_last")
    `STL_ASSERT_NOW(a_end_shape, !empty && o_lex_kind == TT_END, o_token_first && o_run_last && !o_has_byte, "malformed end token")

endmodule

bind script_token_lexer stl_checker u_chk (.*);

// ===== tb/sv/tb_script_token_lexer.sv =====
// self-checking testbench for the streaming script token lexer
module tb_script_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    // generous ceiling on the whole run, in clock cycles
    localparam int LIMIT_CYCLES = 400000;
    // cycles left after the last result so that items with no result drain
    localparam int SETTLE_CYCLES = 8;
    // long receiver hold-off: when it starts and how long it lasts
    localparam int HOLD_AT = 100;
    localparam int HOLD_CYCLES = 150;
    // the keyword, first letter in the top byte
    localparam logic [47:0] KW_WORD = "Output";

    // one result as the lexer should present it
    typedef struct {
        t_tok       tok;
        logic       has;
        logic [7:0] chr;
        logic       first;
        logic       last;
        logic       run_last;
    } t_lex_result;

    // one source item: a byte or an end-of-source marker
    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } t_src_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_char_value = 8'h00;
    logic        i_end_of_source = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_lex_kind;
    logic        o_has_byte;
    logic [7:0]  o_lexeme_byte;
    logic        o_token_first;
    logic        o_token_last;
    logic        o_run_last;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'h0000;

    // source bytes waiting for the driver, results waiting for the lexer
    t_src_item   source_bytes[$];
    t_lex_result token_results_due[$];
    t_lex_result step_results[$];

    // predictor copy of the lexer state and of token_limit
    t_mode       lex_mode = M_TOP;
    logic [2:0]  kw_len = 3'd0;
    logic [15:0] tok_count = 16'd0;
    logic        tok_open = 1'b0;
    logic [15:0] limit_copy = LIMIT_RST;

    int          lexeme_errors = 0;
    int          items_taken = 0;
    int          cycle_count = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        calm = 1'b0;

    script_token_lexer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_char_value    (i_char_value),
        .i_end_of_source (i_end_of_source),
        .empty           (empty),
        .pop             (pop),
        .o_lex_kind      (o_lex_kind),
        .o_has_byte      (o_has_byte),
        .o_lexeme_byte   (o_lexeme_byte),
        .o_token_first   (o_token_first),
        .o_token_last    (o_token_last),
        .o_run_last      (o_run_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // character classes, written out independently of the package
    // ------------------------------------------------------------------
    function automatic logic ch_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic ch_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic ch_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || ch_num(c)
            || c == CH_USCORE;
    endfunction

    function automatic logic [7:0] kw_letter(input int idx);
        return KW_WORD[47 - 8 * idx -: 8];
    endfunction

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------
    task automatic put_res(input t_tok tk, input logic hb, input logic [7:0] ch,
                           input logic fi, input logic la);
        t_lex_result r;
        r.tok      = tk;
        r.has      = hb;
        r.chr      = ch;
        r.first    = fi;
        r.last     = la;
        r.run_last = 1'b0;
        step_results.push_back(r);
    endtask

    // token count saturates rather than wrapping
    task automatic count_tok();
        if (tok_count != 16'hFFFF)
            tok_count = tok_count + 16'd1;
    endtask

    task automatic lexeme_byte(input t_tok tk, input logic [7:0] c);
        put_res(tk, 1'b1, c, !tok_open, 1'b0);
        tok_open = 1'b1;
    endtask

    // closing marker; it is also the first result when the lexeme was empty
    task automatic close_tok(input t_tok tk);
        put_res(tk, 1'b0, 8'h00, !tok_open, 1'b1);
        tok_open = 1'b0;
        count_tok();
    endtask

    // letters of the keyword held back so far turn into a variable
    task automatic flush_prefix();
        for (int i = 0; i < kw_len; i++)
            lexeme_byte(TT_VAR, kw_letter(i));
        kw_len = 3'd0;
    endtask

    // a byte that may start a top-level token; the limit only bites here
    task automatic top_begin(input logic [7:0] c);
        lex_mode = M_TOP;
        tok_open = 1'b0;
        if (tok_count >= limit_copy || ch_blank(c))
            return;
        if (c == CH_BIG_O) begin
            lex_mode = M_KW;
            kw_len = 3'd1;
        end else if (c == CH_LBRACE) begin
            put_res(TT_OPEN, 1'b1, c, 1'b1, 1'b1);
            count_tok();
            lex_mode = M_BRACE;
        end else if (c == CH_COLON) begin
            put_res(TT_ASSIGN, 1'b1, c, 1'b1, 1'b1);
            count_tok();
        end else if (c == CH_LPAREN) begin
            lex_mode = M_TYPE;
        end else if (ch_num(c)) begin
            lexeme_byte(TT_INT, c);
            lex_mode = M_INT;
        end else if (ch_word(c)) begin
            lexeme_byte(TT_VAR, c);
            lex_mode = M_IDENT;
        end else if (c == CH_QUOTE) begin
            lex_mode = M_STR;
        end else if (c == CH_AT) begin
            lexeme_byte(TT_COMMENT, c);
            lex_mode = M_COMMENT;
        end
    endtask

    // inside braces only strings, integers, identifiers and the close count
    task automatic brace_begin(input logic [7:0] c);
        lex_mode = M_BRACE;
        tok_open = 1'b0;
        if (c == CH_RBRACE) begin
            put_res(TT_CLOSE, 1'b1, c, 1'b1, 1'b1);
            count_tok();
            lex_mode = M_TOP;
        end else if (c == CH_QUOTE) begin
            lex_mode = M_BSTR;
        end else if (ch_num(c)) begin
            lexeme_byte(TT_INT, c);
            lex_mode = M_BINT;
        end else if (ch_word(c)) begin
            lexeme_byte(TT_VAR, c);
            lex_mode = M_BIDENT;
        end
    endtask

    // keyword letters are held until the byte after the keyword decides
    task automatic kw_step(input logic [7:0] c);
        if (kw_len < KW_LEN && c == kw_letter(kw_len)) begin
            kw_len = kw_len + 3'd1;
        end else if (kw_len >= KW_LEN && (ch_blank(c) || c == CH_LBRACE)) begin
            for (int i = 0; i < 6; i++)
                put_res(TT_OUTPUT, 1'b1, kw_letter(i), i == 0, i == 5);
            count_tok();
            kw_len = 3'd0;
            top_begin(c);
        end else if (ch_word(c)) begin
            flush_prefix();
            lexeme_byte(TT_VAR, c);
            lex_mode = M_IDENT;
        end else begin
            flush_prefix();
            close_tok(TT_VAR);
            top_begin(c);
        end
    endtask

    task automatic lex_step(input logic [7:0] c);
        logic in_brace;
        in_brace = (lex_mode == M_BIDENT) || (lex_mode == M_BINT);
        case (lex_mode)
            M_KW: begin
                kw_step(c);
            end
            M_IDENT, M_BIDENT: begin
                if (ch_word(c)) begin
                    lexeme_byte(TT_VAR, c);
                end else begin
                    close_tok(TT_VAR);
                    if (in_brace) brace_begin(c); else top_begin(c);
                end
            end
            M_INT, M_BINT: begin
                if (ch_num(c)) begin
                    lexeme_byte(TT_INT, c);
                end else begin
                    close_tok(TT_INT);
                    if (in_brace) brace_begin(c); else top_begin(c);
                end
            end
            M_STR, M_BSTR: begin
                // high bytes vanish from the lexeme without ending it
                if (c == CH_QUOTE) begin
                    close_tok(TT_STRING);
                    if (lex_mode == M_BSTR) lex_mode = M_BRACE; else lex_mode = M_TOP;
                end else if (c < 8'd128) begin
                    lexeme_byte(TT_STRING, c);
                end
            end
            M_TYPE: begin
                if (c == CH_RPAREN) begin
                    close_tok(TT_TYPE);
                    lex_mode = M_TOP;
                end else if (c < 8'd128) begin
                    lexeme_byte(TT_TYPE, c);
                end
            end
            M_COMMENT: begin
                if (c == CH_NL) begin
                    close_tok(TT_COMMENT);
                    lex_mode = M_TOP;
                end else if (c < 8'd128) begin
                    lexeme_byte(TT_COMMENT, c);
                end
            end
            M_BRACE: begin
                brace_begin(c);
            end
            default: begin
                top_begin(c);
            end
        endcase
    endtask

    // end of source closes what is open, sends the end token, rearms
    task automatic source_end();
        case (lex_mode)
            M_KW: begin
                flush_prefix();
                close_tok(TT_VAR);
            end
            M_IDENT, M_BIDENT: close_tok(TT_VAR);
            M_INT, M_BINT:     close_tok(TT_INT);
            M_STR, M_BSTR:     close_tok(TT_STRING);
            M_TYPE:            close_tok(TT_TYPE);
            M_COMMENT:         close_tok(TT_COMMENT);
            default: ;
        endcase
        put_res(TT_END, 1'b0, 8'h00, 1'b1, 1'b1);
        lex_mode = M_TOP;
        kw_len = 3'd0;
        tok_count = 16'd0;
        tok_open = 1'b0;
    endtask

    // work out the results of one accepted item and queue them up
    task automatic tokenise_item(input logic [7:0] c, input logic eos);
        t_lex_result r;
        step_results.delete();
        if (eos)
            source_end();
        else
            lex_step(c);
        for (int i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            token_results_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("lexer mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        lexeme_errors++;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [7:0] c, input logic eos);
        t_src_item s;
        s.ch  = c;
        s.eos = eos;
        source_bytes.push_back(s);
    endtask

    // the byte value rides along with an end marker but must be ignored
    task automatic queue_end();
        queue_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(0, 1) == 0)
            return CH_SPACE;
        return 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0: return 8'("a" + $urandom_range(0, 25));
            1: return 8'("A" + $urandom_range(0, 25));
            2: return 8'("0" + $urandom_range(0, 9));
            default: return CH_USCORE;
        endcase
    endfunction

    // body byte for strings, types and comments, never the closing one
    function automatic logic [7:0] pick_text_char(input logic [7:0] stop);
        logic [7:0] c;
        do begin
            case ($urandom_range(0, 9))
                0: c = 8'($urandom_range(128, 255));
                1: c = 8'($urandom_range(0, 127));
                default: c = 8'($urandom_range(32, 126));
            endcase
        end while (c == stop);
        return c;
    endfunction

    task automatic queue_word();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0)
            queue_item(CH_USCORE, 1'b0);
        else if ($urandom_range(0, 1) == 0)
            queue_item(8'("a" + $urandom_range(0, 25)), 1'b0);
        else
            queue_item(8'("A" + $urandom_range(0, 25)), 1'b0);
        for (int i = 1; i < n; i++)
            queue_item(pick_word_char(), 1'b0);
    endtask

    task automatic queue_number();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            queue_item(8'("0" + $urandom_range(0, 9)), 1'b0);
    endtask

    // opening byte, a short body (possibly empty), closing byte
    task automatic queue_quoted(input logic [7:0] open_ch, input logic [7:0] close_ch);
        int n;
        n = $urandom_range(0, 5);
        queue_item(open_ch, 1'b0);
        for (int i = 0; i < n; i++)
            queue_item(pick_text_char(close_ch), 1'b0);
        queue_item(close_ch, 1'b0);
    endtask

    task automatic queue_block();
        int n;
        logic [7:0] junk;
        n = $urandom_range(0, 4);
        queue_item(CH_LBRACE, 1'b0);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: queue_word();
                1: queue_number();
                2: queue_quoted(CH_QUOTE, CH_QUOTE);
                3: begin
                    do junk = 8'($urandom_range(0, 255));
                    while (junk == CH_RBRACE || junk == CH_QUOTE);
                    queue_item(junk, 1'b0);
                end
                default: queue_item(pick_blank(), 1'b0);
            endcase
        end
        // now and then the block is left open
        if ($urandom_range(0, 9) != 0)
            queue_item(CH_RBRACE, 1'b0);
    endtask

    // the keyword and the ways it can fail to be one
    task automatic queue_keyword();
        int k;
        k = $urandom_range(0, 5);
        if (k == 4) begin
            for (int i = 0; i < $urandom_range(1, 5); i++)
                queue_item(kw_letter(i), 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            queue_text("Output");
            case (k)
                0: queue_item(pick_blank(), 1'b0);
                1: queue_block();
                2: queue_item(pick_word_char(), 1'b0);
                3: queue_item(8'($urandom_range(0, 255)), 1'b0);
                default: queue_end();
            endcase
        end
    endtask

    // mostly well-formed tokens with random content, some noise and ends
    task automatic queue_fragment(input int eos_pct);
        int pick;
        if ($urandom_range(0, 99) < eos_pct) begin
            queue_end();
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 16)
            queue_word();
        else if (pick < 28)
            queue_number();
        else if (pick < 40)
            queue_quoted(CH_QUOTE, CH_QUOTE);
        else if (pick < 50)
            queue_quoted(CH_LPAREN, CH_RPAREN);
        else if (pick < 58)
            queue_quoted(CH_AT, CH_NL);
        else if (pick < 66)
            queue_item(CH_COLON, 1'b0);
        else if (pick < 76)
            queue_keyword();
        else if (pick < 86)
            queue_block();
        else
            queue_item(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 4) < 3)
            queue_item(pick_blank(), 1'b0);
    endtask

    task automatic queue_random(input int n, input int eos_pct);
        int stop_at;
        stop_at = source_bytes.size() + n;
        while (source_bytes.size() < stop_at)
            queue_fragment(eos_pct);
    endtask

    // block idle: all items taken, all results in, stragglers given time
    task automatic wait_drained();
        while (source_bytes.size() != 0 || push || token_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // token_limit is only written while the lexer is idle
    task automatic write_limit(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        limit_copy  = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // source driver: offers items from the queue, with random idle bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : source_driver
        t_src_item nxt;
        if (!i_rst_n) begin
            push   <= 1'b0;
            tx_gap <= 0;
        end else begin
            // item taken at this edge: predict its results now
            if (push && !full) begin
                tokenise_item(i_char_value, i_end_of_source);
                items_taken <= items_taken + 1;
            end
            // a refused item stays on the ports untouched
            if (!(push && full)) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    push   <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    tx_gap <= $urandom_range(0, 18);
                    push   <= 1'b0;
                end else if (source_bytes.size() != 0) begin
                    nxt = source_bytes.pop_front();
                    push            <= 1'b1;
                    i_char_value    <= nxt.ch;
                    i_end_of_source <= nxt.eos;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // one long hold-off on the result side so the command queue fills
    always @(posedge i_clk) begin : result_hold_off
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: takes results, compares with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_lex_result want;
        if (!i_rst_n) begin
            pop    <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (pop && !empty) begin
                if (token_results_due.size() == 0) begin
                    report_mismatch("unexpected result, lex_kind", o_lex_kind, -1);
                end else begin
                    want = token_results_due.pop_front();
                    if (o_lex_kind !== want.tok)
                        report_mismatch("lex_kind", o_lex_kind, int'(want.tok));
                    if (o_has_byte !== want.has)
                        report_mismatch("has_byte", o_has_byte, want.has);
                    if (o_lexeme_byte !== want.chr)
                        report_mismatch("lexeme_byte", o_lexeme_byte, want.chr);
                    if (o_token_first !== want.first)
                        report_mismatch("token_first", o_token_first, want.first);
                    if (o_token_last !== want.last)
                        report_mismatch("token_last", o_token_last, want.last);
                    if (o_run_last !== want.run_last)
                        report_mismatch("run_last", o_run_last, want.run_last);
                end
            end
            if (hold_left != 0) begin
                pop <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap <= rx_gap - 1;
                pop    <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                rx_gap <= $urandom_range(0, 18);
                pop    <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin : run_watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: keyword then brace block with string and integer,
        // assign and empty type, comment with a dropped high byte,
        // keyword prefix turning into a variable ended by a high byte,
        // unterminated string holding byte zero closed by end of source
        queue_text("Output{'s'7}");
        queue_text(":()");
        queue_item(CH_AT, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(CH_NL, 1'b0);
        queue_text("Outpx");
        queue_item(8'h80, 1'b0);
        queue_item(CH_QUOTE, 1'b0);
        queue_item(8'h00, 1'b0);
        queue_end();
        wait_drained();

        // limit of one: a begun brace block is finished, then all dropped
        write_limit(16'd1);
        queue_text("{x}y");
        queue_end();
        wait_drained();

        // largest limit, random source with the long hold-off inside
        write_limit(16'hFFFF);
        queue_random(150, 3);
        wait_drained();

        // tight limit with frequent ends of source so it rearms often
        write_limit(16'($urandom_range(2, 12)));
        queue_random(100, 12);
        wait_drained();

        // last stretch without idling on either side
        write_limit(16'hFFFF);
        calm <= 1'b1;
        queue_random(60, 3);
        queue_end();
        wait_drained();

        if (token_results_due.size() != 0)
            report_mismatch("results never produced", 0, token_results_due.size());
        if (lexeme_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_fifo.sv
rtl/stl_back.sv
rtl/script_token_lexer.sv
rtl/stl_checker.sv
tb/sv/tb_script_token_lexer.sv
